@@ hw/rtl/nbody_gravity_step_unit_assert.svh @@
// Assertion macros for the n-body gravity step unit.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef NBODY_GRAVITY_STEP_UNIT_ASSERT_SVH
`define NBODY_GRAVITY_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define NBGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NBGS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/nbgs_pkg.sv @@
// Shared types, constants and fixed-point helpers of the n-body gravity step unit.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package nbgs_pkg;

    localparam int MAX_BODIES_DEF = 1024;

    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 208;

    localparam logic [1:0] CFG_BODY_COUNT = 2'd0;
    localparam logic [1:0] CFG_TIME_STEP  = 2'd1;
    localparam logic [1:0] CFG_SOFTENING  = 2'd2;
    localparam logic [1:0] CFG_DAMPING    = 2'd3;

    localparam logic [10:0] RST_BODY_COUNT = 11'd1024;
    localparam logic [31:0] RST_TIME_STEP  = 32'd65536;
    localparam logic [31:0] RST_SOFTENING  = 32'd43909;
    localparam logic [15:0] RST_DAMPING    = 16'd65470;

    localparam logic [63:0] WIDE_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic        op_sqrt;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic [63:0] val;
        logic        sat;
    } t_mss;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_c32;

    function automatic logic [63:0] abs64(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // Scale a magnitude product down, clamp it, and put the sign back.
    function automatic t_mss mss_calc(input logic [127:0] p, input logic neg,
                                      input logic sh17, input logic lim63);
        logic [127:0] s;
        logic         over;
        logic [63:0]  mag;
        t_mss         r;
        s    = sh17 ? (p >> 17) : (p >> 16);
        over = lim63 ? (|s[127:63]) : (|s[127:62]);
        mag  = over ? (lim63 ? INT64_LIM : WIDE_LIMIT) : s[63:0];
        r.val = neg ? (64'd0 - mag) : mag;
        r.sat = over;
        return r;
    endfunction

    function automatic t_mss add_sat(input logic [63:0] a, input logic [63:0] b);
        logic signed [63:0] s;
        t_mss               r;
        s = $signed(a) + $signed(b);
        r.sat = 1'b0;
        r.val = s;
        if (s > $signed(WIDE_LIMIT)) begin
            r.val = WIDE_LIMIT;
            r.sat = 1'b1;
        end else if (s < -$signed(WIDE_LIMIT)) begin
            r.val = 64'd0 - WIDE_LIMIT;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic t_c32 clamp32(input logic [63:0] v);
        t_c32 r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if ($signed(v) > 64'sh0000_0000_7FFF_FFFF) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if ($signed(v) < -64'sh0000_0000_8000_0000) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/nbgs_mul.sv @@
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier, one partial product at a time.
// Depends on nbgs_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module nbgs_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nbgs_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic [127:0]           o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic [2:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic [127:0] r_acc;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] pp_shifted;

    always_comb begin
        a_half = r_step[1] ? r_a[63:32] : r_a[31:0];
        b_half = r_step[0] ? r_b[63:32] : r_b[31:0];
        case (r_pp_sh)
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            2'd2:    pp_shifted = {r_pp, 64'd0};
            default: pp_shifted = {64'd0, r_pp};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= 128'd0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // multiply one partial product, add the one before
                if (r_step != 3'd4) begin
                    r_pp    <= 64'(a_half * b_half);
                    r_pp_sh <= 2'({1'b0, r_step[1]} + {1'b0, r_step[0]});
                end
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + pp_shifted;
                end
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/nbgs_divsqrt.sv @@
// Shared iterative unit: 64-bit restoring division or 64-bit integer square root,
// one quotient or root step per cycle. Depends on nbgs_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module nbgs_divsqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire nbgs_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [63:0]            o_res
);

    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_quo;
    logic [63:0] r_bit;
    logic [5:0]  r_cnt;
    logic        r_sqrt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] rem2;
    logic        div_ge;
    logic [64:0] div_diff;
    logic [63:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        rem2     = {r_rem, r_num[63]};
        div_ge   = rem2 >= {1'b0, r_den};
        div_diff = rem2 - {1'b0, r_den};
        // root bits sit above the trial bit, so the sum is an OR
        sq_trial = r_quo | r_bit;
        sq_ge    = r_rem >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.op_sqrt;
                r_quo  <= 64'd0;
                r_den  <= i_req.den;
                r_num  <= i_req.num;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_rem  <= i_req.op_sqrt ? i_req.num : 64'd0;
                r_cnt  <= i_req.op_sqrt ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (sq_ge) begin
                        r_rem <= r_rem - sq_trial;
                        r_quo <= (r_quo >> 1) | r_bit;
                    end else begin
                        r_quo <= r_quo >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_rem <= div_ge ? div_diff[63:0] : rem2[63:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    r_num <= {r_num[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/nbody_gravity_step_unit.sv @@
// Sequence: S_MOD folds an out-of-range index by subtracting MAX_BODIES; a load beat
// is then stored in S_LOAD. A step beat sums the pull of each body (squares, root, two
// divides, products; a zero-distance pair is skipped), then updates velocity and
// position, paced by the shared divide/root unit (one bit per cycle) and the 32x32
// multiplier (four partial products per product); a full output register adds its
// stall. Throughput: one beat at a time, taken only in idle. Reset: synchronous
// active-low; config, state and output valid reset to defaults; body store undefined.
`timescale 1ns / 1ps
`default_nettype none

`include "nbody_gravity_step_unit_assert.svh"

module nbody_gravity_step_unit #(
    parameter int MAX_BODIES = nbgs_pkg::MAX_BODIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: body_index[9:0], load_pos_x, load_pos_y, load_pos_z, load_mass,
    //        load_vel_x, load_vel_y, load_vel_z (32 bits each), zero pad [239:234]
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [nbgs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: func
    input  wire logic                            i_s_tuser,
    // tdata: out_index[9:0], new_pos_x, new_pos_y, new_pos_z,
    //        new_vel_x, new_vel_y, new_vel_z (32 bits each), zero pad [207:202]
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [nbgs_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // tuser: saturated
    output logic                                 o_m_tuser,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data
);

    localparam int          AW   = $clog2(MAX_BODIES);
    localparam int          CW   = $clog2(MAX_BODIES + 1);
    localparam logic [31:0] MAXW = MAX_BODIES;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MOD      = 5'd1;
    localparam logic [4:0] S_LOAD     = 5'd2;
    localparam logic [4:0] S_SELF_RD  = 5'd3;
    localparam logic [4:0] S_SELF_GET = 5'd4;
    localparam logic [4:0] S_PAIR_RD  = 5'd5;
    localparam logic [4:0] S_PAIR_GET = 5'd6;
    localparam logic [4:0] S_SQ       = 5'd7;
    localparam logic [4:0] S_SQ_A     = 5'd8;
    localparam logic [4:0] S_CHK      = 5'd9;
    localparam logic [4:0] S_DIVT     = 5'd10;
    localparam logic [4:0] S_DIVS     = 5'd11;
    localparam logic [4:0] S_SGET     = 5'd12;
    localparam logic [4:0] S_FM       = 5'd13;
    localparam logic [4:0] S_FM_A     = 5'd14;
    localparam logic [4:0] S_NEXT     = 5'd15;
    localparam logic [4:0] S_U_DV     = 5'd16;
    localparam logic [4:0] S_U_V      = 5'd17;
    localparam logic [4:0] S_U_DM     = 5'd18;
    localparam logic [4:0] S_U_VN     = 5'd19;
    localparam logic [4:0] S_U_PM     = 5'd20;
    localparam logic [4:0] S_U_PN     = 5'd21;
    localparam logic [4:0] S_WB       = 5'd22;
    localparam logic [4:0] S_MW       = 5'd23;
    localparam logic [4:0] S_MP       = 5'd24;
    localparam logic [4:0] S_DW       = 5'd25;

    // configuration
    logic [10:0] r_cfg_count;
    logic [31:0] r_cfg_ts;
    logic [31:0] r_cfg_soft;
    logic [15:0] r_cfg_damp;

    // sequencer
    logic [4:0]    r_state;
    logic [4:0]    r_ret;
    logic [1:0]    r_c;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_n;
    logic          r_func;
    logic [9:0]    r_idx;
    logic [223:0]  r_ld;

    // datapath
    logic [31:0] r_pi  [3];
    logic [31:0] r_vi  [3];
    logic [32:0] r_r   [3];
    logic [63:0] r_acc [3];
    logic [31:0] r_vn  [3];
    logic [31:0] r_pn  [3];
    logic [31:0] r_mass;
    logic [63:0] r_d2;
    logic [63:0] r_q;
    logic [63:0] r_s;
    logic [63:0] r_v;
    logic [63:0] r_mss;
    logic        r_neg;
    logic        r_sh17;
    logic        r_lim63;
    logic        r_sat;

    // output register
    logic                            r_out_valid;
    logic [nbgs_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_sat;

    // body store
    logic [31:0] r_mem_px [MAX_BODIES];
    logic [31:0] r_mem_py [MAX_BODIES];
    logic [31:0] r_mem_pz [MAX_BODIES];
    logic [31:0] r_mem_m  [MAX_BODIES];
    logic [31:0] r_mem_vx [MAX_BODIES];
    logic [31:0] r_mem_vy [MAX_BODIES];
    logic [31:0] r_mem_vz [MAX_BODIES];
    logic [31:0] r_rd_px;
    logic [31:0] r_rd_py;
    logic [31:0] r_rd_pz;
    logic [31:0] r_rd_m;
    logic [31:0] r_rd_vx;
    logic [31:0] r_rd_vy;
    logic [31:0] r_rd_vz;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] idx_addr;
    logic          mem_we;
    logic          ld_we;
    logic [31:0]   wd_px;
    logic [31:0]   wd_py;
    logic [31:0]   wd_pz;
    logic [31:0]   wd_vx;
    logic [31:0]   wd_vy;
    logic [31:0]   wd_vz;
    logic          wb_go;
    logic          in_acc;
    logic          out_acc;

    nbgs_pkg::t_mul_req mul_req;
    nbgs_pkg::t_div_req div_req;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic               div_done;
    logic [63:0]        div_res;

    nbgs_pkg::t_mss mss_now;
    nbgs_pkg::t_mss acc_sum;
    nbgs_pkg::t_c32 vn_clamp;
    nbgs_pkg::t_c32 pn_clamp;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_acc     = r_out_valid && i_m_tready;
    assign wb_go       = (r_state == S_WB) && (!r_out_valid || i_m_tready);
    assign idx_addr    = AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= nbgs_pkg::RST_BODY_COUNT;
            r_cfg_ts    <= nbgs_pkg::RST_TIME_STEP;
            r_cfg_soft  <= nbgs_pkg::RST_SOFTENING;
            r_cfg_damp  <= nbgs_pkg::RST_DAMPING;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nbgs_pkg::CFG_BODY_COUNT: r_cfg_count <= i_cfg_data[10:0];
                nbgs_pkg::CFG_TIME_STEP:  r_cfg_ts    <= i_cfg_data;
                nbgs_pkg::CFG_SOFTENING:  r_cfg_soft  <= i_cfg_data;
                nbgs_pkg::CFG_DAMPING:    r_cfg_damp  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared-unit requests and store port selection
    always_comb begin
        mul_req  = '0;
        div_req  = '0;
        rd_addr  = (r_state == S_PAIR_RD) ? r_j[AW-1:0] : idx_addr;
        mss_now  = nbgs_pkg::mss_calc(mul_prod, r_neg, r_sh17, r_lim63);
        acc_sum  = nbgs_pkg::add_sat(r_acc[r_c], r_mss);
        vn_clamp = nbgs_pkg::clamp32(r_mss);
        pn_clamp = nbgs_pkg::clamp32({{32{r_pi[r_c][31]}}, r_pi[r_c]} + r_mss);
        unique case (r_state)
            S_SQ: begin
                mul_req.start = 1'b1;
                mul_req.a     = nbgs_pkg::abs64({{31{r_r[r_c][32]}}, r_r[r_c]});
                mul_req.b     = mul_req.a;
            end
            S_FM: begin
                mul_req.start = 1'b1;
                mul_req.a     = nbgs_pkg::abs64({{31{r_r[r_c][32]}}, r_r[r_c]});
                mul_req.b     = r_s;
            end
            S_U_DV: begin
                mul_req.start = 1'b1;
                mul_req.a     = nbgs_pkg::abs64(r_acc[r_c]);
                mul_req.b     = {32'd0, r_cfg_ts};
            end
            S_U_DM: begin
                mul_req.start = 1'b1;
                mul_req.a     = nbgs_pkg::abs64(r_v);
                mul_req.b     = {48'd0, r_cfg_damp};
            end
            S_U_PM: begin
                mul_req.start = 1'b1;
                mul_req.a     = nbgs_pkg::abs64({{32{r_vn[r_c][31]}}, r_vn[r_c]});
                mul_req.b     = {32'd0, r_cfg_ts};
            end
            S_CHK: begin
                div_req.start   = (r_d2 != 64'd0);
                div_req.op_sqrt = 1'b1;
                div_req.num     = {r_d2[49:0], 14'd0};
            end
            S_DIVT: begin
                div_req.start = 1'b1;
                div_req.num   = {r_mass, 32'd0};
                div_req.den   = r_d2;
            end
            S_DIVS: begin
                div_req.start = 1'b1;
                div_req.num   = div_res;
                div_req.den   = r_q;
            end
            default: ;
        endcase
    end

    nbgs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    nbgs_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_c     <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func  <= i_s_tuser;
                        r_idx   <= i_s_tdata[9:0];
                        r_ld    <= i_s_tdata[233:10];
                        r_n     <= (32'(r_cfg_count) > MAXW) ? CW'(MAXW) : CW'(r_cfg_count);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_sat <= 1'b0;
                    if (32'(r_idx) >= MAXW) begin
                        r_idx <= r_idx - 10'(MAXW);
                    end else begin
                        r_state <= r_func ? S_SELF_RD : S_LOAD;
                    end
                end
                S_LOAD:    r_state <= S_IDLE;
                S_SELF_RD: r_state <= S_SELF_GET;
                S_SELF_GET: begin
                    r_pi[0] <= r_rd_px;
                    r_pi[1] <= r_rd_py;
                    r_pi[2] <= r_rd_pz;
                    r_vi[0] <= r_rd_vx;
                    r_vi[1] <= r_rd_vy;
                    r_vi[2] <= r_rd_vz;
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k] <= 64'd0;
                    end
                    r_j     <= '0;
                    r_c     <= 2'd0;
                    r_state <= (r_n == '0) ? S_U_DV : S_PAIR_RD;
                end
                S_PAIR_RD: r_state <= S_PAIR_GET;
                S_PAIR_GET: begin
                    r_r[0]  <= {r_rd_px[31], r_rd_px} - {r_pi[0][31], r_pi[0]};
                    r_r[1]  <= {r_rd_py[31], r_rd_py} - {r_pi[1][31], r_pi[1]};
                    r_r[2]  <= {r_rd_pz[31], r_rd_pz} - {r_pi[2][31], r_pi[2]};
                    r_mass  <= r_rd_m;
                    r_d2    <= {32'd0, r_cfg_soft};
                    r_c     <= 2'd0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_neg   <= 1'b0;
                    r_sh17  <= 1'b0;
                    r_lim63 <= 1'b1;
                    r_ret   <= S_SQ_A;
                    r_state <= S_MW;
                end
                S_SQ_A: begin
                    r_d2 <= r_d2 + r_mss;
                    if (r_c == 2'd2) begin
                        r_c     <= 2'd0;
                        r_state <= S_CHK;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_CHK: begin
                    // zero distance: skip the pair
                    r_ret   <= S_DIVT;
                    r_state <= (r_d2 == 64'd0) ? S_NEXT : S_DW;
                end
                S_DIVT: begin
                    // hold the root; t goes on to the second divide
                    r_q     <= div_res;
                    r_ret   <= S_DIVS;
                    r_state <= S_DW;
                end
                S_DIVS: begin
                    r_ret   <= S_SGET;
                    r_state <= S_DW;
                end
                S_SGET: begin
                    r_s     <= div_res;
                    r_state <= S_FM;
                end
                S_FM: begin
                    r_neg   <= r_r[r_c][32];
                    r_sh17  <= 1'b1;
                    r_lim63 <= 1'b0;
                    r_ret   <= S_FM_A;
                    r_state <= S_MW;
                end
                S_FM_A: begin
                    r_acc[r_c] <= acc_sum.val;
                    r_sat      <= r_sat | acc_sum.sat;
                    if (r_c == 2'd2) begin
                        r_c     <= 2'd0;
                        r_state <= S_NEXT;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_FM;
                    end
                end
                S_NEXT: begin
                    r_c <= 2'd0;
                    if (r_j + CW'(1) == r_n) begin
                        r_state <= S_U_DV;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_PAIR_RD;
                    end
                end
                S_U_DV: begin
                    r_neg   <= r_acc[r_c][63];
                    r_sh17  <= 1'b0;
                    r_lim63 <= 1'b0;
                    r_ret   <= S_U_V;
                    r_state <= S_MW;
                end
                S_U_V: begin
                    r_v     <= {{32{r_vi[r_c][31]}}, r_vi[r_c]} + r_mss;
                    r_state <= S_U_DM;
                end
                S_U_DM: begin
                    r_neg   <= r_v[63];
                    r_sh17  <= 1'b0;
                    r_lim63 <= 1'b1;
                    r_ret   <= S_U_VN;
                    r_state <= S_MW;
                end
                S_U_VN: begin
                    r_vn[r_c] <= vn_clamp.val;
                    r_sat     <= r_sat | vn_clamp.sat;
                    r_state   <= S_U_PM;
                end
                S_U_PM: begin
                    r_neg   <= r_vn[r_c][31];
                    r_sh17  <= 1'b0;
                    r_lim63 <= 1'b0;
                    r_ret   <= S_U_PN;
                    r_state <= S_MW;
                end
                S_U_PN: begin
                    r_pn[r_c] <= pn_clamp.val;
                    r_sat     <= r_sat | pn_clamp.sat;
                    if (r_c == 2'd2) begin
                        r_c     <= 2'd0;
                        r_state <= S_WB;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_U_DV;
                    end
                end
                S_WB: begin
                    // hold until the output register is free
                    if (wb_go) begin
                        r_state <= S_IDLE;
                    end
                end
                S_MW: begin
                    if (mul_done) begin
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_mss   <= mss_now.val;
                    r_sat   <= r_sat | mss_now.sat;
                    r_state <= r_ret;
                end
                S_DW: begin
                    if (div_done) begin
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        ld_we  = (r_state == S_LOAD);
        mem_we = ld_we || wb_go;
        wd_px  = ld_we ? r_ld[31:0]    : r_pn[0];
        wd_py  = ld_we ? r_ld[63:32]   : r_pn[1];
        wd_pz  = ld_we ? r_ld[95:64]   : r_pn[2];
        wd_vx  = ld_we ? r_ld[159:128] : r_vn[0];
        wd_vy  = ld_we ? r_ld[191:160] : r_vn[1];
        wd_vz  = ld_we ? r_ld[223:192] : r_vn[2];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_px[idx_addr] <= wd_px;
            r_mem_py[idx_addr] <= wd_py;
            r_mem_pz[idx_addr] <= wd_pz;
            r_mem_vx[idx_addr] <= wd_vx;
            r_mem_vy[idx_addr] <= wd_vy;
            r_mem_vz[idx_addr] <= wd_vz;
        end
        if (ld_we) begin
            r_mem_m[idx_addr] <= r_ld[127:96];
        end
        r_rd_px <= r_mem_px[rd_addr];
        r_rd_py <= r_mem_py[rd_addr];
        r_rd_pz <= r_mem_pz[rd_addr];
        r_rd_m  <= r_mem_m[rd_addr];
        r_rd_vx <= r_mem_vx[rd_addr];
        r_rd_vy <= r_mem_vy[rd_addr];
        r_rd_vz <= r_mem_vz[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (wb_go) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {6'd0, r_vn[2], r_vn[1], r_vn[0],
                                r_pn[2], r_pn[1], r_pn[0], r_idx};
                r_out_sat   <= r_sat;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

    `NBGS_ASSERT_IMP(a_mul_done_in_wait, i_clk, i_rst_n, mul_done, r_state == S_MW, "multiplier finished outside its wait state")
    `NBGS_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == S_DW, "divider finished outside its wait state")
    `NBGS_ASSERT_IMP(a_pair_in_range, i_clk, i_rst_n, r_state == S_PAIR_RD, (r_j < r_n) && (32'(r_idx) < MAXW), "pair walk out of range")
    `NBGS_ASSERT_NXT(a_result_posted, i_clk, i_rst_n, wb_go, o_m_tvalid && (r_state == S_IDLE), "write-back did not post a result")

endmodule

`default_nettype wire
